// ===== hdl/srte_pkg.sv =====
package srte_pkg;

	localparam int NODES       = 32;
	localparam int NODE_BITS   = 5;
	localparam int WEIGHT_BITS = 16;
	localparam int PRICE_BITS  = 20;
	localparam int DIST_BITS   = 21;
	localparam int MAX_HOPS    = 31;
	localparam int EDGE_DEPTH  = NODES * NODES;
	localparam int EDGE_ABITS  = 2 * NODE_BITS;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY  = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_ROUTE = 2'd1,
		STAT_UNKNOWN  = 2'd2,
		STAT_NO_EDGE  = 2'd3
	} stat_code_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_A,
		ST_ADD_B,
		ST_REM_RD,
		ST_REM_CHK,
		ST_REM_B,
		ST_QRY_CHK,
		ST_QRY_DIR,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_RELAX,
		ST_RELAX_END,
		ST_ROUTE,
		ST_WALK_P,
		ST_WALK_E,
		ST_WALK_OUT,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic [1:0]             req_type;
		logic [NODE_BITS-1:0]   first_node;
		logic [NODE_BITS-1:0]   second_node;
		logic [WEIGHT_BITS-1:0] edge_weight;
		logic [PRICE_BITS-1:0]  edge_price;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [NODE_BITS-1:0]   hop_from;
		logic [NODE_BITS-1:0]   hop_to;
		logic [WEIGHT_BITS-1:0] hop_distance;
		logic [PRICE_BITS-1:0]  hop_price;
		logic [DIST_BITS-1:0]   total_distance;
		logic                   direct_known;
		logic [PRICE_BITS-1:0]  direct_price;
		logic                   last;
	} res_t;

	typedef struct packed {
		logic                   valid;
		logic [WEIGHT_BITS-1:0] weight;
		logic [PRICE_BITS-1:0]  cost;
	} edge_word_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] total;
		logic [NODE_BITS-1:0] pred;
	} node_word_t;

endpackage

// ===== hdl/srte_ram.sv =====
module srte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ABITS = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ABITS-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [ABITS-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/shortest_route_engine_core.sv =====
// add writes both edge directions; remove reads and checks the edge, then clears both
//   directions, or stops at a status error; query: setup, a scan and relax pass per
//   settled node, a closing scan, the route check, then a walk per hop; one request at
//   a time, the node memory port visited once per node in each scan and relax pass
// a new request is taken while the previous result still waits in the output register
// reset: asynchronous, active low; then a clearing pass over every edge memory entry, no requests
module shortest_route_engine_core
	import srte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	state_t state_q, state_d;

	req_t                   req_q;
	logic [EDGE_ABITS-1:0]  clr_q;
	logic [NODES-1:0]       present_q, pv_q, settled_q;
	logic [NODE_BITS-1:0]   v_q, v_s1, best_q, cur_q, prev_q, hop_q;
	logic [DIST_BITS-1:0]   best_d_q, tot_q;
	logic                   found_q, scan_s1, relax_s1;
	logic                   dir_known_q;
	logic [PRICE_BITS-1:0]  dir_price_q;
	logic [1:0]             stat_q;
	logic                   out_valid_q;
	res_t                   out_q;

	// memory ports
	logic                  e_we, e_re, n_we, n_re;
	logic [EDGE_ABITS-1:0] e_waddr, e_raddr;
	logic [NODE_BITS-1:0]  n_waddr, n_raddr;
	edge_word_t            e_wdata, e_rd;
	node_word_t            n_wdata, n_rd;
	logic [$bits(edge_word_t)-1:0] e_rdata;
	logic [$bits(node_word_t)-1:0] n_rdata;

	logic [1:0]           stat_nx;
	logic                 out_free, load_stat, load_hop;
	logic [NODE_BITS-1:0] a_node, b_node;
	logic                 known, reach_v, upd, take, hop_last;
	logic [DIST_BITS-1:0] nd;
	res_t                 stat_res, hop_res;

	srte_ram #(.WIDTH($bits(edge_word_t)), .DEPTH(EDGE_DEPTH)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	srte_ram #(.WIDTH($bits(node_word_t)), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	assign e_rd   = edge_word_t'(e_rdata);
	assign n_rd   = node_word_t'(n_rdata);
	assign a_node = req_q.first_node;
	assign b_node = req_q.second_node;
	assign known  = present_q[a_node] && present_q[b_node];

	// relax and scan stage one, after the memory read
	assign reach_v = (v_s1 == a_node) || pv_q[v_s1];
	assign nd      = best_d_q + DIST_BITS'(e_rd.weight);
	assign upd     = relax_s1 && e_rd.valid && (!reach_v || nd < n_rd.total);
	assign take    = scan_s1 && reach_v && !settled_q[v_s1]
		&& (!found_q || n_rd.total < best_d_q);

	assign out_free = !out_valid_q || !res_stall;
	assign hop_last = (prev_q == a_node) || (hop_q == NODE_BITS'(MAX_HOPS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (&clr_q) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) begin
					case (req_data.req_type)
						REQ_ADD:    state_d = ST_ADD_A;
						REQ_REMOVE: state_d = ST_REM_RD;
						REQ_QUERY:  state_d = ST_QRY_CHK;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_A:     state_d = ST_ADD_B;
			ST_ADD_B:     state_d = ST_STATUS;
			ST_REM_RD:    state_d = known ? ST_REM_CHK : ST_STATUS;
			ST_REM_CHK:   state_d = e_rd.valid ? ST_REM_B : ST_STATUS;
			ST_REM_B:     state_d = ST_STATUS;
			ST_QRY_CHK:   state_d = (known && a_node != b_node) ? ST_QRY_DIR : ST_STATUS;
			ST_QRY_DIR:   state_d = ST_SCAN;
			ST_SCAN:      if (v_q == NODE_BITS'(NODES - 1)) state_d = ST_SCAN_END;
			ST_SCAN_END:  state_d = ST_PICK;
			ST_PICK:      state_d = found_q ? ST_RELAX : ST_ROUTE;
			ST_RELAX:     if (v_q == NODE_BITS'(NODES - 1)) state_d = ST_RELAX_END;
			ST_RELAX_END: state_d = ST_SCAN;
			ST_ROUTE:     state_d = pv_q[b_node] ? ST_WALK_P : ST_STATUS;
			ST_WALK_P:    state_d = ST_WALK_E;
			ST_WALK_E:    state_d = ST_WALK_OUT;
			ST_WALK_OUT:  if (out_free) state_d = hop_last ? ST_IDLE : ST_WALK_P;
			ST_STATUS:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory controls and strobes
	always_comb begin
		e_we      = 1'b0;
		e_waddr   = {a_node, b_node};
		e_wdata   = '{valid: 1'b1, weight: req_q.edge_weight, cost: req_q.edge_price};
		e_re      = 1'b0;
		e_raddr   = {a_node, b_node};
		n_we      = 1'b0;
		n_waddr   = v_s1;
		n_wdata   = '{total: nd, pred: best_q};
		n_re      = 1'b0;
		n_raddr   = v_q;
		stat_nx   = STAT_OK;
		load_stat = 1'b0;
		load_hop  = 1'b0;
		req_stall = (state_q != ST_IDLE);
		if (upd) begin
			n_we = 1'b1;
		end
		unique case (state_q)
			ST_CLEAR: begin
				e_we    = 1'b1;
				e_waddr = clr_q;
				e_wdata = '0;
			end
			ST_ADD_A: e_we = 1'b1;
			ST_ADD_B: begin
				e_we    = 1'b1;
				e_waddr = {b_node, a_node};
			end
			ST_REM_RD: begin
				e_re    = 1'b1;
				stat_nx = STAT_UNKNOWN;
			end
			ST_REM_CHK: begin
				e_we          = e_rd.valid;
				e_wdata.valid = 1'b0;
				stat_nx       = STAT_NO_EDGE;
			end
			ST_REM_B: begin
				e_we          = 1'b1;
				e_waddr       = {b_node, a_node};
				e_wdata.valid = 1'b0;
			end
			ST_QRY_CHK: begin
				e_re    = 1'b1;
				n_we    = 1'b1;
				n_waddr = a_node;
				n_wdata = '0;
				stat_nx = known ? STAT_NO_ROUTE : STAT_UNKNOWN;
			end
			ST_SCAN:  n_re = 1'b1;
			ST_RELAX: begin
				n_re    = 1'b1;
				e_re    = 1'b1;
				e_raddr = {best_q, v_q};
			end
			ST_ROUTE: stat_nx = STAT_NO_ROUTE;
			ST_WALK_P: begin
				n_re    = 1'b1;
				n_raddr = cur_q;
			end
			ST_WALK_E: begin
				e_re    = 1'b1;
				e_raddr = {n_rd.pred, cur_q};
			end
			ST_WALK_OUT: load_hop = out_free;
			ST_STATUS:   load_stat = out_free;
			default: ;
		endcase
	end

	// result words for the output register
	always_comb begin
		stat_res        = '0;
		stat_res.status = stat_q;
		stat_res.last   = 1'b1;

		hop_res                = '0;
		hop_res.status         = STAT_OK;
		hop_res.hop_from       = prev_q;
		hop_res.hop_to         = cur_q;
		hop_res.hop_distance   = e_rd.weight;
		hop_res.hop_price      = e_rd.cost;
		hop_res.total_distance = (hop_q == '0) ? tot_q : '0;
		hop_res.direct_known   = (hop_q == '0) ? dir_known_q : 1'b0;
		hop_res.direct_price   = (hop_q == '0 && dir_known_q) ? dir_price_q : '0;
		hop_res.last           = hop_last;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			present_q   <= '0;
			pv_q        <= '0;
			settled_q   <= '0;
			found_q     <= 1'b0;
			scan_s1     <= 1'b0;
			relax_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			scan_s1  <= (state_q == ST_SCAN);
			relax_s1 <= (state_q == ST_RELAX);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_ADD_B) begin
				present_q <= present_q | (NODES'(1) << a_node) | (NODES'(1) << b_node);
			end
			if (state_q == ST_QRY_CHK) begin
				pv_q      <= '0;
				settled_q <= '0;
			end
			if (upd) begin
				pv_q[v_s1] <= 1'b1;
			end
			// minimum search over reached, unsettled nodes
			if (state_q == ST_QRY_DIR || state_q == ST_RELAX_END) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_PICK && found_q) begin
				settled_q[best_q] <= 1'b1;
			end
			// output register
			if (load_stat || load_hop) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		v_s1 <= v_q;
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req_data;
		end
		if (state_d == ST_STATUS && state_q != ST_STATUS) begin
			stat_q <= stat_nx;
		end
		if (state_q == ST_QRY_DIR || state_q == ST_PICK) begin
			v_q <= '0;
		end else if (state_q == ST_SCAN || state_q == ST_RELAX) begin
			v_q <= v_q + 1'b1;
		end
		if (state_q == ST_QRY_DIR) begin
			dir_known_q <= e_rd.valid;
			dir_price_q <= e_rd.cost;
		end
		if (take) begin
			best_q   <= v_s1;
			best_d_q <= n_rd.total;
		end
		// route walk from destination back to start
		if (state_q == ST_ROUTE) begin
			cur_q <= b_node;
			hop_q <= '0;
		end
		if (state_q == ST_WALK_E) begin
			prev_q <= n_rd.pred;
			if (hop_q == '0) begin
				tot_q <= n_rd.total;
			end
		end
		if (load_hop) begin
			cur_q <= prev_q;
			hop_q <= hop_q + 1'b1;
		end
		if (load_stat) begin
			out_q <= stat_res;
		end else if (load_hop) begin
			out_q <= hop_res;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule
